[hdl/ihq_pkg.sv]
// ihq_pkg: shared types and codes for the indexed min-heap queue.
// Holds the heap entry word, action and status codes and parameter defaults.
// No dependencies.
`default_nettype none
package ihq_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DEF_ID_COUNT = 256;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SETKEY = 2'd1;
	localparam logic [1:0] ACT_DELMIN = 2'd2;
	localparam logic [1:0] ACT_REMOVE = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic        [7:0]  id;
		logic signed [31:0] key;
	} ihq_entry_t;

endpackage
`default_nettype wire

[hdl/ihq_ram.sv]
// ihq_ram: simple dual-port synchronous memory, one write and one read port.
// Read data is registered. No dependencies.
`default_nettype none
module ihq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/indexed_min_heap_queue.sv]
// indexed_min_heap_queue: indexed binary min-heap with an id-to-slot table.
// Depends on ihq_pkg and ihq_ram (heap store and position table).
//
// A command word is taken when start is high and busy is low; its result
// (status, out_id, out_key) appears for exactly one cycle with done high,
// and must be captured then. Each command runs its setup states and then
// a sift-up or a sift-down, in which every level needs one or two reads
// of the single heap read port; busy stays high until done, so a new word
// is taken only after the last one has finished. After reset the block
// holds busy while it clears the position table.
`default_nettype none
module indexed_min_heap_queue
	import ihq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ID_COUNT = DEF_ID_COUNT
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [1:0]        action,
	input  wire  [7:0]        item_id,
	input  wire signed [31:0] item_key,
	output logic              done,
	output logic [2:0]        status,
	output logic [7:0]        out_id,
	output logic signed [31:0] out_key
);

	localparam int SW = $clog2(CAPACITY);
	localparam int PW = $clog2(ID_COUNT);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LOOK  = 4'd2;
	localparam logic [3:0] S_RMV   = 4'd3;
	localparam logic [3:0] S_TAKE  = 4'd4;
	localparam logic [3:0] S_FILL  = 4'd5;
	localparam logic [3:0] S_FILLP = 4'd6;
	localparam logic [3:0] S_UPRD  = 4'd7;
	localparam logic [3:0] S_UPDAT = 4'd8;
	localparam logic [3:0] S_DNRD  = 4'd9;
	localparam logic [3:0] S_DNL   = 4'd10;
	localparam logic [3:0] S_DNR   = 4'd11;
	localparam logic [3:0] S_PLACE = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;

	logic [3:0]         state_q;
	logic [PW-1:0]      clr_q;
	logic [1:0]         act_q;
	logic [7:0]         id_q;
	logic signed [31:0] key_q;
	logic               idok_q;
	logic [SW-1:0]      p_q;
	logic [SW-1:0]      cnt_q;
	ihq_entry_t         m_q;
	ihq_entry_t         e_q;
	ihq_entry_t         lc_q;
	logic [2:0]         st_q;
	logic [7:0]         rid_q;
	logic signed [31:0] rkey_q;

	logic               h_we;
	logic [SW-1:0]      h_waddr;
	ihq_entry_t         h_wdata;
	logic [SW-1:0]      h_raddr;
	ihq_entry_t         h_rdata;
	logic               p_we;
	logic [PW-1:0]      p_waddr;
	logic [SW-1:0]      p_wdata;
	logic [PW-1:0]      p_raddr;
	logic [SW-1:0]      p_rdata;

	logic [SW:0]        c2;
	logic [SW:0]        cnt_x;
	logic               found;
	logic               pick_r;
	ihq_entry_t         pick;
	logic [SW:0]        pick_idx;

	ihq_ram #(.WIDTH($bits(ihq_entry_t)), .DEPTH(CAPACITY)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	ihq_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_pos (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign c2     = {p_q, 1'b0};
	assign cnt_x  = {1'b0, cnt_q};
	assign found  = idok_q && (p_rdata != '0) && (p_rdata <= cnt_q);
	assign pick_r = $signed(h_rdata.key) < $signed(lc_q.key);
	assign pick   = pick_r ? h_rdata : lc_q;
	assign pick_idx = pick_r ? (c2 + 1'b1) : c2;

	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_FIN);
	assign status  = st_q;
	assign out_id  = rid_q;
	assign out_key = rkey_q;

	always_comb begin
		h_we    = 1'b0;
		h_waddr = p_q;
		h_wdata = m_q;
		h_raddr = p_q >> 1;
		p_we    = 1'b0;
		p_waddr = PW'(m_q.id);
		p_wdata = p_q;
		p_raddr = PW'(item_id);
		unique case (state_q)
			S_CLR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = '0;
			end
			S_IDLE: h_raddr = SW'(1);
			S_LOOK: h_raddr = p_rdata;
			S_TAKE: begin
				p_we    = 1'b1;
				p_waddr = PW'(e_q.id);
				p_wdata = '0;
				h_raddr = cnt_q;
			end
			S_UPDAT: begin
				if ($signed(m_q.key) <= $signed(h_rdata.key)) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					p_we    = 1'b1;
					p_waddr = PW'(h_rdata.id);
				end
			end
			S_DNRD: h_raddr = SW'(c2);
			S_DNL: begin
				h_raddr = SW'(c2 + 1'b1);
				if (!(c2 < cnt_x) && ($signed(h_rdata.key) < $signed(m_q.key))) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					p_we    = 1'b1;
					p_waddr = PW'(h_rdata.id);
				end
			end
			S_DNR: begin
				if ($signed(pick.key) < $signed(m_q.key)) begin
					h_we    = 1'b1;
					h_wdata = pick;
					p_we    = 1'b1;
					p_waddr = PW'(pick.id);
				end
			end
			S_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			st_q    <= ST_OK;
			rid_q   <= '0;
			rkey_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PW'(ID_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q   <= action;
						id_q    <= item_id;
						key_q   <= item_key;
						idok_q  <= 32'(item_id) < ID_COUNT;
						st_q    <= ST_OK;
						rid_q   <= '0;
						rkey_q  <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					unique case (act_q)
						ACT_INSERT: begin
							if (cnt_q >= SW'(CAPACITY - 1)) begin
								st_q    <= ST_FULL;
								state_q <= S_FIN;
							end else if (!idok_q) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_FIN;
							end else if (found) begin
								st_q    <= ST_DUP;
								state_q <= S_FIN;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								p_q     <= cnt_q + 1'b1;
								m_q     <= '{id: id_q, key: key_q};
								state_q <= S_UPRD;
							end
						end
						ACT_DELMIN: begin
							if (cnt_q == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								e_q     <= h_rdata;
								p_q     <= SW'(1);
								state_q <= S_TAKE;
							end
						end
						default: begin
							if (!found) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_FIN;
							end else begin
								p_q     <= p_rdata;
								state_q <= S_RMV;
							end
						end
					endcase
				end
				S_RMV: begin
					if (act_q == ACT_SETKEY) begin
						m_q <= '{id: id_q, key: key_q};
						if ($signed(h_rdata.key) > $signed(key_q)) begin
							state_q <= S_UPRD;
						end else if ($signed(h_rdata.key) < $signed(key_q)) begin
							state_q <= S_DNRD;
						end else begin
							state_q <= S_PLACE;
						end
					end else begin
						e_q     <= h_rdata;
						state_q <= S_TAKE;
					end
				end
				S_TAKE: begin
					rid_q  <= e_q.id;
					rkey_q <= e_q.key;
					cnt_q  <= cnt_q - 1'b1;
					state_q <= (p_q == cnt_q) ? S_FIN : S_FILL;
				end
				S_FILL: begin
					m_q     <= h_rdata;
					state_q <= (p_q > SW'(1)) ? S_FILLP : S_DNRD;
				end
				S_FILLP: begin
					state_q <= ($signed(m_q.key) < $signed(h_rdata.key)) ? S_UPDAT : S_DNRD;
				end
				S_UPRD: begin
					state_q <= (p_q > SW'(1)) ? S_UPDAT : S_PLACE;
				end
				S_UPDAT: begin
					if ($signed(m_q.key) <= $signed(h_rdata.key)) begin
						p_q     <= p_q >> 1;
						state_q <= S_UPRD;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DNRD: begin
					state_q <= (c2 <= cnt_x) ? S_DNL : S_PLACE;
				end
				S_DNL: begin
					lc_q <= h_rdata;
					if (c2 < cnt_x) begin
						state_q <= S_DNR;
					end else if ($signed(h_rdata.key) < $signed(m_q.key)) begin
						p_q     <= SW'(c2);
						state_q <= S_DNRD;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DNR: begin
					if ($signed(pick.key) < $signed(m_q.key)) begin
						p_q     <= SW'(pick_idx);
						state_q <= S_DNRD;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: state_q <= S_FIN;
				S_FIN:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SW'(CAPACITY - 1))
		else $error("heap count beyond capacity");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_EMPTY))
		else $error("illegal status code");

endmodule
`default_nettype wire
